/* rtl/wip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wip_pkg: shared types and constants
// Command and status groups between the controller and the datapath, plus the
// fixed widths and constants of the windowed idle percentage block.
// ----------------------------------------------------------------------------
package wip_pkg;

  localparam int PCT_W     = 7;
  localparam int COUNTER_W = 32;

  localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic prime;      // take the first sample as the baseline
    logic capture;    // take a sample and form its deltas
    logic update;     // update running sums, ring and fill count
    logic div_start;  // start a division
    logic div_sel;    // 0: window sums, 1: cumulative counters
    logic latch_rec;  // keep the windowed quotient
    logic load_out;   // load the output register
  } wip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;   // the divider has a quotient ready
    logic out_free;   // the output register can take a new result
  } wip_status_t;

  // Address width for a memory of the given depth, at least one bit.
  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

/* rtl/wip_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wip_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wip_ram
  import wip_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 100
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [addr_bits(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]            wdata,
  input  wire logic                        re,
  input  wire logic [addr_bits(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/wip_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wip_divider: saturating percentage divider
// Computes min(100 * part / whole, 100), or 0 for a zero whole, one quotient
// bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module wip_divider
  import wip_pkg::*;
#(
  parameter int OPER_W = 39
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OPER_W-1:0] part,
  input  wire logic [OPER_W-1:0] whole,
  output logic                   done,
  output logic      [PCT_W-1:0]  quotient
);

  localparam int REM_W = OPER_W + PCT_W;

  logic                     busy;
  logic [$clog2(PCT_W)-1:0] cnt;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         dsr;
  logic [REM_W:0]           diff;
  logic [REM_W-1:0]         part_ext;

  assign part_ext = REM_W'(part);
  assign diff     = {1'b0, rem} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      if (whole == '0) begin
        quotient <= '0;
        done     <= 1'b1;
        busy     <= 1'b0;
      end else if (part >= whole) begin
        quotient <= PERCENT_SCALE;
        done     <= 1'b1;
        busy     <= 1'b0;
      end else begin
        // Quotient stays below 100, so seven bits are enough.
        rem      <= (part_ext << 6) + (part_ext << 5) + (part_ext << 2);
        dsr      <= REM_W'(whole) << (PCT_W - 1);
        cnt      <= ($clog2(PCT_W))'(PCT_W - 1);
        quotient <= '0;
        done     <= 1'b0;
        busy     <= 1'b1;
      end
    end else if (busy) begin
      if (!diff[REM_W]) begin
        rem           <= diff[REM_W-1:0];
        quotient[cnt] <= 1'b1;
      end
      dsr <= dsr >> 1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* rtl/wip_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wip_datapath: sample deltas, window ring, running sums and divider
// Holds the baselines, the delta ring, the running sums, the fill count and
// the output register, and runs the divisions the controller asks for.
// ----------------------------------------------------------------------------
module wip_datapath
  import wip_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wip_cmd_t             cmd,
  output wip_status_t               status,
  input  wire logic [COUNTER_W-1:0] idle_time_now,
  input  wire logic [COUNTER_W-1:0] total_time_now,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic      [PCT_W-1:0]     recent_percent,
  output logic      [PCT_W-1:0]     cumulative_percent,
  output logic      [PCT_W-1:0]     window_fill
);

  localparam int SLOT_W = addr_bits(WINDOW_SAMPLES);
  localparam int FILL_W = $clog2(WINDOW_SAMPLES + 1);
  localparam int SUM_W  = COUNTER_W + FILL_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SAMPLES - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW_SAMPLES);

  logic [COUNTER_W-1:0]   last_idle;
  logic [COUNTER_W-1:0]   last_total;
  logic [COUNTER_W-1:0]   idle_now;
  logic [COUNTER_W-1:0]   total_now;
  logic [COUNTER_W-1:0]   d_idle;
  logic [COUNTER_W-1:0]   d_total;
  logic [SLOT_W-1:0]      write_slot;
  logic [FILL_W-1:0]      fill_count;
  logic [SUM_W-1:0]       idle_sum;
  logic [SUM_W-1:0]       total_sum;
  logic [2*COUNTER_W-1:0] ring_rdata;
  logic [COUNTER_W-1:0]   old_idle;
  logic [COUNTER_W-1:0]   old_total;
  logic                   window_full;
  logic [SUM_W-1:0]       div_part;
  logic [SUM_W-1:0]       div_whole;
  logic                   div_done;
  logic [PCT_W-1:0]       div_q;
  logic [PCT_W-1:0]       rec_q;

  // Until the window has wrapped, the slot being replaced was never written
  // and counts as zero.
  assign window_full = (fill_count == FULL);
  assign old_idle    = window_full ? ring_rdata[2*COUNTER_W-1:COUNTER_W] : '0;
  assign old_total   = window_full ? ring_rdata[COUNTER_W-1:0] : '0;

  wip_ram #(
    .WIDTH (2 * COUNTER_W),
    .DEPTH (WINDOW_SAMPLES)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (write_slot),
    .wdata ({d_idle, d_total}),
    .re    (cmd.capture),
    .raddr (write_slot),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.prime || cmd.capture) begin
      last_idle  <= idle_time_now;
      last_total <= total_time_now;
    end
    if (cmd.capture) begin
      idle_now  <= idle_time_now;
      total_now <= total_time_now;
      d_idle    <= idle_time_now - last_idle;
      d_total   <= total_time_now - last_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      idle_sum   <= '0;
      total_sum  <= '0;
    end else if (cmd.update) begin
      idle_sum   <= idle_sum - SUM_W'(old_idle) + SUM_W'(d_idle);
      total_sum  <= total_sum - SUM_W'(old_total) + SUM_W'(d_total);
      write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      if (!window_full) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  assign div_part  = cmd.div_sel ? SUM_W'(idle_now) : idle_sum;
  assign div_whole = cmd.div_sel ? SUM_W'(total_now) : total_sum;

  wip_divider #(
    .OPER_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .part     (div_part),
    .whole    (div_whole),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_rec) begin
      rec_q <= div_q;
    end
    if (cmd.load_out) begin
      recent_percent     <= rec_q;
      cumulative_percent <= div_q;
      window_fill        <= PCT_W'(fill_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

/* rtl/wip_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wip_controller: sequencing state machine
// Accepts samples, tracks priming, and steps the datapath through the ring
// update, the two divisions and the output load.
// ----------------------------------------------------------------------------
module wip_controller
  import wip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire wip_status_t status,
  output wip_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_UPDATE    = 6'b000010,
    S_START_REC = 6'b000100,
    S_WAIT_REC  = 6'b001000,
    S_WAIT_CUM  = 6'b010000,
    S_EMIT      = 6'b100000
  } wip_state_t;

  wip_state_t state;
  wip_state_t state_next;
  logic       primed;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.prime   = !primed;
          cmd.capture = primed;
          if (primed) begin
            state_next = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_START_REC;
      end
      S_START_REC: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_REC;
      end
      S_WAIT_REC: begin
        if (status.div_done) begin
          cmd.latch_rec = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_WAIT_CUM;
        end
      end
      S_WAIT_CUM: begin
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      primed <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        primed <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/windowed_idle_percentage_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_idle_percentage_top: sliding-window idle percentage
// Turns cumulative idle and total runtime counters into a windowed and a
// cumulative idle percentage.
// ----------------------------------------------------------------------------
// Each input transfer carries the cumulative idle and total runtime counters.
// The first transfer after reset only records them as baselines and produces
// no result. Every later transfer stores the wrapped deltas in a ring of
// WINDOW_SAMPLES entries (one RAM, idle and total side by side), keeps running
// sums over the valid entries, and produces one result transfer with the
// windowed idle percentage, the cumulative idle percentage (each 0 for a zero
// divisor and capped at 100) and the number of samples in the window. Slots
// the ring has not yet wrapped onto read as zero through the fill count, so
// no clearing pass follows reset. A priming transfer does not take the block out
// of its idle state. Any other transfer keeps the input side busy until its
// result is loaded: the two percentages share one restoring divider that
// produces one quotient bit per cycle, and a division with a zero divisor or
// with a part no smaller than the whole finishes as soon as it is started.
// A finished result sits in the output register while the next sample is
// accepted; the block waits before its own output load only if that result
// has still not been taken.
// ----------------------------------------------------------------------------
module windowed_idle_percentage_top
  import wip_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [COUNTER_W-1:0] idle_time_now,
  input  wire logic [COUNTER_W-1:0] total_time_now,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [PCT_W-1:0]     recent_percent,
  output logic      [PCT_W-1:0]     cumulative_percent,
  output logic      [PCT_W-1:0]     window_fill
);

  wip_cmd_t    cmd;
  wip_status_t status;

  // The controller decides when; the datapath holds every value.
  wip_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wip_datapath #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .idle_time_now      (idle_time_now),
    .total_time_now     (total_time_now),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .recent_percent     (recent_percent),
    .cumulative_percent (cumulative_percent),
    .window_fill        (window_fill)
  );

endmodule
`default_nettype wire

/* rtl/wip_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wip_checker: port-level checks
// Watches the top level's ports for result ranges, handshake holding and
// reset and accept behavior.
// ----------------------------------------------------------------------------
module wip_checker
  import wip_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 100
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [COUNTER_W-1:0] idle_time_now,
  input wire logic [COUNTER_W-1:0] total_time_now,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [PCT_W-1:0]     recent_percent,
  input wire logic [PCT_W-1:0]     cumulative_percent,
  input wire logic [PCT_W-1:0]     window_fill
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(recent_percent)
      && $stable(cumulative_percent) && $stable(window_fill))
    else $error("stalled result changed");

  // Results stay in range and, for windows up to 127 samples, a result always has at least one sample.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> recent_percent <= PERCENT_SCALE
      && cumulative_percent <= PERCENT_SCALE
      && ((WINDOW_SAMPLES > 127) || window_fill != '0))
    else $error("result out of range");

  // The block only goes busy because it accepted a sample.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input side went busy without a transfer");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // An input transfer never carries unknown counter bits.
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !$isunknown({idle_time_now, total_time_now}))
    else $error("unknown input payload on transfer");

endmodule

bind windowed_idle_percentage_top wip_checker #(
  .WINDOW_SAMPLES (WINDOW_SAMPLES)
) u_wip_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .idle_time_now      (idle_time_now),
  .total_time_now     (total_time_now),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .recent_percent     (recent_percent),
  .cumulative_percent (cumulative_percent),
  .window_fill        (window_fill)
);
`default_nettype wire
